// ===== hw/rtl/trcs_pkg.sv =====
// Shared constants, types and register codes for the toon ramp color sampler.
`default_nettype none
package trcs_pkg;

	localparam int FRAC_BITS  = 14;
	localparam int COORD_W    = FRAC_BITS + 1;
	localparam int CH_W       = 8;
	localparam int NUM_CH     = 3;
	localparam int COLOR_W    = CH_W * NUM_CH;

	localparam int T_FRAC     = 16;
	localparam int T_W        = T_FRAC + 1;
	localparam int DIV_BITS   = T_W;
	localparam int MIX_SHIFT  = 3 * T_FRAC;
	localparam int P_W        = MIX_SHIFT + 1;
	localparam int SQ_W       = 2 * T_FRAC;
	localparam int K_W        = T_FRAC + 2;

	localparam int SMOOTH_LAT = 2;
	localparam int LERP_LAT   = 2;
	localparam int LAT        = 2 + DIV_BITS + 1 + SMOOTH_LAT + 2 * LERP_LAT;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = COLOR_W;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [T_W-1:0]     weight_t;
	typedef logic [P_W-1:0]     power_t;

	localparam weight_t T_ONE  = {1'b1, {T_FRAC{1'b0}}};
	localparam weight_t T_HALF = {2'b01, {(T_FRAC-1){1'b0}}};
	localparam power_t  P_ONE  = {1'b1, {MIX_SHIFT{1'b0}}};

	localparam logic [CFG_IDX_W-1:0] REG_LIGHT       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHADOW      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SOFTNESS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_COLOR  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_CENTER = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_WIDTH  = 3'd6;

	localparam color_t RST_LIGHT    = 24'hFFFFFF;
	localparam color_t RST_SHADOW   = 24'hD2D2D2;
	localparam coord_t RST_BOUNDARY = {2'b01, {(FRAC_BITS-1){1'b0}}};
	localparam coord_t RST_SOFTNESS = COORD_W'(492);

	// Flags that ride along with the two dividers.
	typedef struct packed {
		logic ge;
		logic hard;
		logic sat;
		logic in_band;
	} side_t;

endpackage
`default_nettype wire

// ===== hw/rtl/toon_ramp_color_sampler.sv =====
// Top level of the toon ramp color sampler: config registers and the sample pipeline.
`default_nettype none
// The sampler takes one coordinate per clock whenever start is high (busy is
// always low) and delivers its color with done high for one cycle; the
// receiver cannot stall, so results must be taken as they come. The pipeline
// runs through the two 17-stage dividers (one quotient bit per stage), then
// the weight register, the two-stage smoothstep and the two chained two-stage
// lerps. Configuration writes take effect at once and must only happen while
// no item is in flight.
module toon_ramp_color_sampler (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire trcs_pkg::coord_t                   coord,
	input  wire logic                               cfg_we,
	input  wire logic [trcs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [trcs_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                                    done,
	output logic [trcs_pkg::CH_W-1:0]               red,
	output logic [trcs_pkg::CH_W-1:0]               green,
	output logic [trcs_pkg::CH_W-1:0]               blue
);
	import trcs_pkg::*;

	color_t    light_q;
	color_t    shadow_q;
	coord_t    boundary_q;
	coord_t    softness_q;
	color_t    band_color_q;
	coord_t    band_center_q;
	coord_t    band_width_q;

	logic              accept;
	logic [LAT-1:0]    vld_s;

	coord_t            coord_s1;
	logic              ge;
	coord_t            d_edge;
	coord_t            e_band;
	logic [COORD_W:0]  two_e;
	side_t             side_in;
	coord_t            d_edge_s2;
	coord_t            n_band_s2;
	side_t             side_s2;
	side_t             side_dly_s [DIV_BITS];

	weight_t           q_edge;
	logic              rnz_edge;
	weight_t           q_band;
	side_t             side_out;
	logic [T_W:0]      q_up;
	logic [T_W:0]      q_dn;
	weight_t           t_next;
	weight_t           t_s20;
	weight_t           u_s20;

	power_t            p_edge;
	power_t            p_band;
	power_t            p_band_s [LERP_LAT];
	color_t            rgb_base;
	color_t            rgb_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q       <= RST_LIGHT;
			shadow_q      <= RST_SHADOW;
			boundary_q    <= RST_BOUNDARY;
			softness_q    <= RST_SOFTNESS;
			band_color_q  <= '0;
			band_center_q <= '0;
			band_width_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LIGHT:       light_q       <= cfg_data;
				REG_SHADOW:      shadow_q      <= cfg_data;
				REG_BOUNDARY:    boundary_q    <= cfg_data[COORD_W-1:0];
				REG_SOFTNESS:    softness_q    <= cfg_data[COORD_W-1:0];
				REG_BAND_COLOR:  band_color_q  <= cfg_data;
				REG_BAND_CENTER: band_center_q <= cfg_data[COORD_W-1:0];
				REG_BAND_WIDTH:  band_width_q  <= cfg_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LAT-2:0], accept};
		end
	end

	assign done = vld_s[LAT-1];

	always_ff @(posedge clk) begin
		coord_s1 <= coord;
	end

	// Distances to the edge and to the band center, and the flags that pick
	// how the quotients are used later.
	assign ge     = coord_s1 >= boundary_q;
	assign d_edge = ge ? coord_s1 - boundary_q : boundary_q - coord_s1;
	assign e_band = (coord_s1 >= band_center_q) ? coord_s1 - band_center_q
	                                            : band_center_q - coord_s1;
	assign two_e  = {e_band, 1'b0};

	always_comb begin
		side_in.ge      = ge;
		side_in.hard    = softness_q == '0;
		side_in.sat     = {1'b0, d_edge} >= {softness_q, 1'b0};
		side_in.in_band = (band_width_q != '0) && (two_e < {1'b0, band_width_q});
	end

	always_ff @(posedge clk) begin
		d_edge_s2 <= d_edge;
		n_band_s2 <= band_width_q - two_e[COORD_W-1:0];
		side_s2   <= side_in;
		side_dly_s[0] <= side_s2;
		for (int k = 1; k < DIV_BITS; k++) begin
			side_dly_s[k] <= side_dly_s[k-1];
		end
	end

	trcs_div u_div_edge (
		.clk    (clk),
		.num    (d_edge_s2),
		.den    (softness_q),
		.quo    (q_edge),
		.rem_nz (rnz_edge)
	);

	trcs_div u_div_band (
		.clk    (clk),
		.num    (n_band_s2),
		.den    (band_width_q),
		.quo    (q_band),
		.rem_nz ()
	);

	assign side_out = side_dly_s[DIV_BITS-1];
	assign q_up     = {1'b0, q_edge} + {1'b0, T_HALF};
	assign q_dn     = {1'b0, q_edge} + {{T_W{1'b0}}, rnz_edge};

	// Above the boundary the floor quotient is used; below it the ceiling,
	// so that the negated offset rounds toward minus infinity.
	always_comb begin
		if (side_out.hard) begin
			t_next = side_out.ge ? T_ONE : '0;
		end else if (side_out.ge) begin
			t_next = (side_out.sat || q_edge > T_HALF) ? T_ONE : q_up[T_W-1:0];
		end else begin
			t_next = (side_out.sat || q_dn >= {1'b0, T_HALF}) ? '0
			                                                  : T_HALF - q_dn[T_W-1:0];
		end
	end

	// Outside the band the weight is zero, which leaves the base color as is.
	always_ff @(posedge clk) begin
		t_s20 <= t_next;
		u_s20 <= side_out.in_band ? q_band : '0;
	end

	trcs_smooth u_smooth_edge (
		.clk (clk),
		.t   (t_s20),
		.p   (p_edge)
	);

	trcs_smooth u_smooth_band (
		.clk (clk),
		.t   (u_s20),
		.p   (p_band)
	);

	always_ff @(posedge clk) begin
		p_band_s[0] <= p_band;
		for (int k = 1; k < LERP_LAT; k++) begin
			p_band_s[k] <= p_band_s[k-1];
		end
	end

	trcs_lerp u_lerp_base (
		.clk (clk),
		.a   (light_q),
		.b   (shadow_q),
		.p   (p_edge),
		.y   (rgb_base)
	);

	trcs_lerp u_lerp_band (
		.clk (clk),
		.a   (rgb_base),
		.b   (band_color_q),
		.p   (p_band_s[LERP_LAT-1]),
		.y   (rgb_out)
	);

	assign red   = rgb_out[COLOR_W-1 -: CH_W];
	assign green = rgb_out[COLOR_W-1-CH_W -: CH_W];
	assign blue  = rgb_out[CH_W-1:0];

endmodule
`default_nettype wire

// ===== hw/rtl/trcs_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for (num << 16) / den.
`default_nettype none
module trcs_div (
	input  wire logic             clk,
	input  wire trcs_pkg::coord_t num,
	input  wire trcs_pkg::coord_t den,
	output trcs_pkg::weight_t     quo,
	output logic                  rem_nz
);
	import trcs_pkg::*;

	coord_t            rem_s  [DIV_BITS];
	weight_t           quo_s  [DIV_BITS];
	logic [COORD_W:0]  step_r [DIV_BITS];

	// Returns {quotient bit, new remainder}. The remainder stays below den
	// whenever the quotient fits in DIV_BITS bits.
	function automatic logic [COORD_W:0] div_step(input coord_t rem, input logic nbit,
			input coord_t d);
		logic [COORD_W:0] trial;
		logic [COORD_W:0] diff;
		trial = {rem, nbit};
		diff  = trial - {1'b0, d};
		if (trial >= {1'b0, d}) begin
			return {1'b1, diff[COORD_W-1:0]};
		end
		return {1'b0, trial[COORD_W-1:0]};
	endfunction

	always_comb begin
		step_r[0] = div_step({1'b0, num[COORD_W-1:1]}, num[0], den);
		for (int k = 1; k < DIV_BITS; k++) begin
			step_r[k] = div_step(rem_s[k-1], 1'b0, den);
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= step_r[0][COORD_W-1:0];
		quo_s[0] <= {{(DIV_BITS-1){1'b0}}, step_r[0][COORD_W]};
		for (int k = 1; k < DIV_BITS; k++) begin
			rem_s[k] <= step_r[k][COORD_W-1:0];
			quo_s[k] <= {quo_s[k-1][DIV_BITS-2:0], step_r[k][COORD_W]};
		end
	end

	assign quo    = quo_s[DIV_BITS-1];
	assign rem_nz = |rem_s[DIV_BITS-1];

endmodule
`default_nettype wire

// ===== hw/rtl/trcs_smooth.sv =====
// Two-stage smoothstep weight: p = t*t*(3 - 2t) scaled to 2^48.
`default_nettype none
module trcs_smooth (
	input  wire logic              clk,
	input  wire trcs_pkg::weight_t t,
	output trcs_pkg::power_t       p
);
	import trcs_pkg::*;

	localparam logic [K_W-1:0] K_BASE = K_W'(3) << T_FRAC;

	logic [SQ_W-1:0]      sq_s1;
	logic [K_W-1:0]       k_s1;
	logic                 full_s1;
	logic [SQ_W+K_W-1:0]  prod;
	power_t               p_s2;

	// Only t == 1.0 sets the top bit, and then the weight is exactly one.
	always_ff @(posedge clk) begin
		sq_s1   <= t[T_FRAC-1:0] * t[T_FRAC-1:0];
		k_s1    <= K_BASE - {1'b0, t[T_FRAC-1:0], 1'b0};
		full_s1 <= t[T_FRAC];
	end

	assign prod = sq_s1 * k_s1;

	always_ff @(posedge clk) begin
		p_s2 <= full_s1 ? P_ONE : prod[P_W-1:0];
	end

	assign p = p_s2;

endmodule
`default_nettype wire

// ===== hw/rtl/trcs_lerp.sv =====
// Two-stage three-channel lerp from a to b by weight p, rounding half up.
`default_nettype none
module trcs_lerp (
	input  wire logic             clk,
	input  wire trcs_pkg::color_t a,
	input  wire trcs_pkg::color_t b,
	input  wire trcs_pkg::power_t p,
	output trcs_pkg::color_t      y
);
	import trcs_pkg::*;

	localparam int PR_W = CH_W + 1 + P_W + 1;
	localparam int SH_W = PR_W - MIX_SHIFT;
	localparam logic signed [PR_W-1:0] RND = PR_W'(1) << (MIX_SHIFT - 1);

	logic signed [CH_W:0]   diff    [NUM_CH];
	logic signed [PR_W-1:0] prod    [NUM_CH];
	logic signed [PR_W-1:0] prod_s1 [NUM_CH];
	logic signed [PR_W-1:0] rnd     [NUM_CH];
	logic [SH_W-1:0]        sum     [NUM_CH];
	color_t                 a_s1;
	color_t                 y_s2;

	// a*(1-p) + b*p is rewritten as a + (b-a)*p, with an arithmetic shift.
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			diff[c] = $signed({1'b0, b[COLOR_W-1-CH_W*c -: CH_W]})
			        - $signed({1'b0, a[COLOR_W-1-CH_W*c -: CH_W]});
			prod[c] = diff[c] * $signed({1'b0, p});
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= a;
		for (int c = 0; c < NUM_CH; c++) begin
			prod_s1[c] <= prod[c];
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			rnd[c] = prod_s1[c] + RND;
			sum[c] = SH_W'(a_s1[COLOR_W-1-CH_W*c -: CH_W]) + rnd[c][PR_W-1:MIX_SHIFT];
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NUM_CH; c++) begin
			y_s2[COLOR_W-1-CH_W*c -: CH_W] <= sum[c][CH_W-1:0];
		end
	end

	assign y = y_s2;

endmodule
`default_nettype wire

// ===== hw/rtl/trcs_chk.sv =====
// Port-level checks on the sampler's item timing, bound to the top level.
`default_nettype none
module trcs_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);
	import trcs_pkg::*;

	// Every accepted item comes out after the fixed pipeline latency.
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted item did not produce a result on time");

	// No result appears without an item accepted the latency earlier.
	a_done_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching accepted item");

	// The pipeline never refuses an item.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind toon_ramp_color_sampler trcs_chk u_trcs_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
`default_nettype wire

// ===== dv/tb_toon_ramp_color_sampler.sv =====
// Self-checking testbench for the toon ramp color sampler: directed corners, then random phases.
module tb_toon_ramp_color_sampler;
	timeunit 1ns;
	timeprecision 1ps;

	import trcs_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
	localparam longint unsigned WEIGHT_ONE = 64'd65536;
	localparam int PHASES = 14;
	localparam int PHASE_ITEMS = 50;

	typedef logic [CFG_DATA_W-1:0] cfg_word_t;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} rgb_t;

	typedef struct {
		coord_t coord;
		rgb_t   rgb;
	} sample_t;

	typedef struct {
		color_t light;
		color_t shadow;
		color_t band;
		coord_t boundary;
		coord_t softness;
		coord_t band_center;
		coord_t band_width;
	} ramp_cfg_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	coord_t            coord;
	logic              cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	cfg_word_t         cfg_data;
	logic              done;
	logic [CH_W-1:0]   red;
	logic [CH_W-1:0]   green;
	logic [CH_W-1:0]   blue;

	ramp_cfg_t cfg_now;
	sample_t   pending_colors[$];
	sample_t   head;
	int        errors = 0;
	bit        gaps_on = 1'b1;

	toon_ramp_color_sampler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.coord     (coord),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	always #6 clk = ~clk;

	// Smoothstep of a Q1.16 weight, then a round-half-up lerp from a to b.
	function automatic logic [CH_W-1:0] smooth_blend(logic [CH_W-1:0] a, logic [CH_W-1:0] b,
			longint unsigned t);
		longint unsigned p;
		longint unsigned acc;
		p = t * t * (3 * WEIGHT_ONE - 2 * t);
		acc = 64'(a) * ((64'd1 << 48) - p) + 64'(b) * p + (64'd1 << 47);
		return CH_W'(acc >> 48);
	endfunction

	function automatic rgb_t shade_coord(coord_t v);
		longint unsigned vv, bnd, swid, q, t, u, e, bc, bw;
		rgb_t c;
		vv = v;
		bnd = cfg_now.boundary;
		swid = cfg_now.softness;
		if (swid == 0) begin
			t = (vv >= bnd) ? WEIGHT_ONE : 0;
		end else if (vv >= bnd) begin
			q = ((vv - bnd) << 16) / swid;
			t = q + WEIGHT_ONE / 2;
			if (t > WEIGHT_ONE) t = WEIGHT_ONE;
		end else begin
			// Rounding the magnitude up makes the signed quotient round toward minus infinity.
			q = (((bnd - vv) << 16) + swid - 1) / swid;
			t = (q >= WEIGHT_ONE / 2) ? 0 : WEIGHT_ONE / 2 - q;
		end
		c.r = smooth_blend(cfg_now.light[23:16], cfg_now.shadow[23:16], t);
		c.g = smooth_blend(cfg_now.light[15:8], cfg_now.shadow[15:8], t);
		c.b = smooth_blend(cfg_now.light[7:0], cfg_now.shadow[7:0], t);
		bc = cfg_now.band_center;
		bw = cfg_now.band_width;
		if (bw != 0) begin
			e = (vv >= bc) ? vv - bc : bc - vv;
			if (2 * e < bw) begin
				u = ((bw - 2 * e) << 16) / bw;
				c.r = smooth_blend(c.r, cfg_now.band[23:16], u);
				c.g = smooth_blend(c.g, cfg_now.band[15:8], u);
				c.b = smooth_blend(c.b, cfg_now.band[7:0], u);
			end
		end
		return c;
	endfunction

	task automatic check_chan(string name, coord_t c, logic [CH_W-1:0] exp_v,
			logic [CH_W-1:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch for coord %0d: expected %0d, actual %0d",
				$time, name, c, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_colors.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual %0d %0d %0d",
					$time, red, green, blue);
			end else begin
				head = pending_colors.pop_front();
				check_chan("red", head.coord, head.rgb.r, red);
				check_chan("green", head.coord, head.rgb.g, green);
				check_chan("blue", head.coord, head.rgb.b, blue);
			end
		end
	end

	// Leaves cfg_we high; the caller lowers it after its last write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, cfg_word_t data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_LIGHT:       cfg_now.light = data;
			REG_SHADOW:      cfg_now.shadow = data;
			REG_BOUNDARY:    cfg_now.boundary = data[COORD_W-1:0];
			REG_SOFTNESS:    cfg_now.softness = data[COORD_W-1:0];
			REG_BAND_COLOR:  cfg_now.band = data;
			REG_BAND_CENTER: cfg_now.band_center = data[COORD_W-1:0];
			REG_BAND_WIDTH:  cfg_now.band_width = data[COORD_W-1:0];
			default: ;
		endcase
	endtask

	// Junk in the bits above a coordinate register must be dropped.
	function automatic cfg_word_t pad_coord(coord_t x);
		cfg_word_t d;
		d = cfg_word_t'($urandom);
		d[COORD_W-1:0] = x;
		return d;
	endfunction

	task automatic load_setting(ramp_cfg_t s);
		write_reg(REG_LIGHT, s.light);
		write_reg(REG_SHADOW, s.shadow);
		write_reg(REG_BOUNDARY, pad_coord(s.boundary));
		write_reg(REG_SOFTNESS, pad_coord(s.softness));
		write_reg(REG_BAND_COLOR, s.band);
		write_reg(REG_BAND_CENTER, pad_coord(s.band_center));
		write_reg(REG_BAND_WIDTH, pad_coord(s.band_width));
		cfg_we <= 1'b0;
	endtask

	task automatic drain_pipeline();
		start <= 1'b0;
		while (pending_colors.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_coord(coord_t v);
		int gap;
		gap = gaps_on ? $urandom_range(0, 6) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			coord <= coord_t'($urandom);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		coord <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_colors.push_back('{v, shade_coord(v)});
	endtask

	function automatic color_t random_color();
		case ($urandom_range(0, 5))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			default: return color_t'($urandom);
		endcase
	endfunction

	function automatic ramp_cfg_t random_setting();
		ramp_cfg_t s;
		s.light = random_color();
		s.shadow = random_color();
		s.band = random_color();
		case ($urandom_range(0, 5))
			0: s.boundary = 0;
			1: s.boundary = 16384;
			2: s.boundary = coord_t'($urandom_range(16385, 32767));
			default: s.boundary = coord_t'($urandom_range(0, 16384));
		endcase
		case ($urandom_range(0, 7))
			0: s.softness = 0;
			1: s.softness = coord_t'($urandom_range(1, 16));
			2: s.softness = 16384;
			3: s.softness = 32767;
			default: s.softness = coord_t'($urandom_range(1, 16384));
		endcase
		case ($urandom_range(0, 5))
			0: s.band_center = 0;
			1: s.band_center = 16384;
			default: s.band_center = coord_t'($urandom_range(0, 16384));
		endcase
		case ($urandom_range(0, 7))
			0, 1: s.band_width = 0;
			2: s.band_width = 1;
			3: s.band_width = 16384;
			4: s.band_width = 32767;
			default: s.band_width = coord_t'($urandom_range(1, 8192));
		endcase
		return s;
	endfunction

	function automatic coord_t near(int base, int span);
		int x;
		x = base + int'($urandom_range(0, 2 * span)) - span;
		if (x < 0) x = 0;
		if (x > 32767) x = 32767;
		return coord_t'(x);
	endfunction

	// Half of the coordinates land around the edge or around the band, where the arithmetic works.
	function automatic coord_t pick_coord();
		case ($urandom_range(0, 9))
			0, 1, 2: return near(cfg_now.boundary, cfg_now.softness + 4);
			3, 4:    return near(cfg_now.band_center, cfg_now.band_width / 2 + 4);
			5: begin
				case ($urandom_range(0, 3))
					0: return 0;
					1: return 16384;
					2: return 32767;
					default: return coord_t'(1 << $urandom_range(0, 14));
				endcase
			end
			6: return coord_t'($urandom_range(0, 32767));
			default: return coord_t'($urandom_range(0, 16384));
		endcase
	endfunction

	task automatic test_reset_values();
		send_coord(0);
		send_coord(8192);
		send_coord(16384);
		send_coord(32767);
		send_coord(8192 - 246);
		send_coord(8192 + 246);
	endtask

	task automatic test_hard_step();
		ramp_cfg_t s;
		drain_pipeline();
		s = cfg_now;
		s.light = 24'h000000;
		s.shadow = 24'hFFFFFF;
		s.boundary = 5000;
		s.softness = 0;
		load_setting(s);
		send_coord(4999);
		send_coord(5000);
		send_coord(5001);
		drain_pipeline();
		s.boundary = 0;
		load_setting(s);
		send_coord(0);
	endtask

	task automatic test_soft_edge();
		ramp_cfg_t s;
		drain_pipeline();
		s = cfg_now;
		s.light = 24'hFFFFFF;
		s.shadow = 24'h000000;
		s.boundary = 32767;
		s.softness = 32767;
		load_setting(s);
		send_coord(0);
		send_coord(32767);
		drain_pipeline();
		s.boundary = 100;
		s.softness = 1;
		load_setting(s);
		send_coord(99);
		send_coord(100);
		send_coord(101);
	endtask

	task automatic test_band();
		ramp_cfg_t s;
		drain_pipeline();
		s.light = 24'h102030;
		s.shadow = 24'hF0E0D0;
		s.band = 24'hFF00FF;
		s.boundary = 8192;
		s.softness = 4096;
		s.band_center = 8000;
		s.band_width = 2000;
		load_setting(s);
		send_coord(8000);
		// Exactly on the band edge the band must have no effect.
		send_coord(7000);
		send_coord(7001);
		send_coord(8999);
		send_coord(9000);
		drain_pipeline();
		s.band_center = 0;
		s.band_width = 1;
		load_setting(s);
		send_coord(0);
	endtask

	task automatic test_unknown_index();
		drain_pipeline();
		write_reg(REG_NONE, 24'hFFFFFF);
		cfg_we <= 1'b0;
		send_coord(12345);
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_pipeline();
			load_setting(random_setting());
			gaps_on = ($urandom_range(0, 3) != 0);
			repeat (PHASE_ITEMS) send_coord(pick_coord());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		coord = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cfg_now.light = RST_LIGHT;
		cfg_now.shadow = RST_SHADOW;
		cfg_now.band = '0;
		cfg_now.boundary = RST_BOUNDARY;
		cfg_now.softness = RST_SOFTNESS;
		cfg_now.band_center = '0;
		cfg_now.band_width = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_hard_step();
		test_soft_edge();
		test_band();
		test_unknown_index();
		test_random_phases();
		drain_pipeline();
		repeat (LAT) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
